// ===== rtl/bdc_pkg.sv =====
// Shared types and constants for the button debounce and click detector.
`timescale 1ns / 1ps
package bdc_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int IDX_W       = 3;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 48;

  localparam logic [7:0]  SETTLE_RESET = 8'd10;
  localparam logic [15:0] WINDOW_RESET = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE_COUNT  = 3'd0,
    CFG_DOUBLE_CLICK  = 3'd1,
    CFG_EXCLUSIVE     = 3'd2,
    CFG_PRESSED_LEVEL = 3'd3,
    CFG_BUTTON_COUNT  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  settle_count;
    logic [15:0] double_click_ms;
    logic        exclusive_mode;
    logic        pressed_level;
    logic [3:0]  button_count;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              pin_level;
    logic [IDX_W-1:0]  button_index;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] held_ms;
    logic              debounced_level;
    logic              double_click;
    logic              click;
    logic              went_up;
    logic              went_down;
    logic              state_changed;
    logic [IDX_W-1:0]  button_id;
  } result_t;

  typedef struct packed {
    logic              stable_level;
    logic              previous_raw;
    logic [7:0]        agree_count;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] last_click_time;
    logic [TIME_W-1:0] hold_duration;
    logic              click_valid;
  } btn_state_t;

endpackage

// ===== rtl/bdc_cfg.sv =====
// Configuration register bank for the button debounce and click detector.
`timescale 1ns / 1ps
module bdc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output bdc_pkg::cfg_t                   cfg
);

  bdc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_count    <= bdc_pkg::SETTLE_RESET;
      cfg_r.double_click_ms <= bdc_pkg::WINDOW_RESET;
      cfg_r.exclusive_mode  <= 1'b0;
      cfg_r.pressed_level   <= 1'b0;
      cfg_r.button_count    <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdc_pkg::CFG_SETTLE_COUNT:  cfg_r.settle_count    <= cfg_wdata[7:0];
        bdc_pkg::CFG_DOUBLE_CLICK:  cfg_r.double_click_ms <= cfg_wdata[15:0];
        bdc_pkg::CFG_EXCLUSIVE:     cfg_r.exclusive_mode  <= cfg_wdata[0];
        bdc_pkg::CFG_PRESSED_LEVEL: cfg_r.pressed_level   <= cfg_wdata[0];
        bdc_pkg::CFG_BUTTON_COUNT:  cfg_r.button_count    <= cfg_wdata[3:0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/bdc_core.sv =====
// Per-button state table and single-pass debounce and click update.
`timescale 1ns / 1ps
module bdc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  bdc_pkg::item_t   item,
  input  bdc_pkg::cfg_t    cfg,
  output bdc_pkg::result_t res
);

  bdc_pkg::btn_state_t state_r [bdc_pkg::NUM_BUTTONS];
  bdc_pkg::btn_state_t cur;
  bdc_pkg::btn_state_t upd_nxt;

  logic                       active;
  logic                       flipped;
  logic [7:0]                 cnt_inc;
  logic [bdc_pkg::TIME_W-1:0] click_diff;
  logic                       in_window;
  logic                       window_over;
  logic                       is_down;

  assign cur         = state_r[item.button_index];
  assign active      = {1'b0, item.button_index} < cfg.button_count;
  assign cnt_inc     = cur.agree_count + 8'd1;
  assign click_diff  = item.now_ms - cur.last_click_time;
  assign in_window   = cur.click_valid && (click_diff <= {16'd0, cfg.double_click_ms});
  assign window_over = click_diff >= {16'd0, cfg.double_click_ms};

  always_comb begin
    upd_nxt = cur;
    flipped = 1'b0;
    res     = '0;
    res.button_id = item.button_index;

    // Debounce: count agreeing samples that differ from the settled level
    if (item.pin_level != cur.stable_level) begin
      if (item.pin_level == cur.previous_raw) begin
        upd_nxt.agree_count = cnt_inc;
        if (cnt_inc == cfg.settle_count) begin
          upd_nxt.stable_level = ~cur.stable_level;
          upd_nxt.agree_count  = 8'd0;
          flipped              = 1'b1;
        end
      end else begin
        upd_nxt.agree_count = 8'd0;
      end
      upd_nxt.previous_raw = item.pin_level;
    end

    is_down = upd_nxt.stable_level == cfg.pressed_level;

    if (flipped) begin
      res.state_changed     = 1'b1;
      upd_nxt.hold_duration = '0;
      if (!is_down) begin
        res.went_up = 1'b1;
        if (cfg.exclusive_mode) begin
          if (in_window) begin
            res.double_click    = 1'b1;
            upd_nxt.click_valid = 1'b0;
          end else begin
            upd_nxt.last_click_time = item.now_ms;
            upd_nxt.click_valid     = 1'b1;
          end
        end else begin
          res.double_click        = in_window;
          res.click               = 1'b1;
          upd_nxt.last_click_time = item.now_ms;
          upd_nxt.click_valid     = 1'b1;
        end
        upd_nxt.press_time = '0;
      end else begin
        res.went_down      = 1'b1;
        upd_nxt.press_time = item.now_ms;
      end
    end else if (is_down) begin
      upd_nxt.hold_duration = item.now_ms - cur.press_time;
    end else if (cfg.exclusive_mode && cur.click_valid && window_over) begin
      // window ran out with no second click: release the pending single click
      res.click           = 1'b1;
      upd_nxt.click_valid = 1'b0;
    end

    // Inactive button: hold state, report stored level and hold time only
    if (!active) begin
      upd_nxt = cur;
      res     = '0;
      res.button_id = item.button_index;
    end

    res.debounced_level = upd_nxt.stable_level;
    res.held_ms         = upd_nxt.hold_duration;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bdc_pkg::NUM_BUTTONS; i++) begin
        state_r[i] <= '0;
      end
    end else if (fire && active) begin
      state_r[item.button_index] <= upd_nxt;
    end
  end

endmodule

// ===== rtl/button_debounce_click_detector_unit.sv =====
// An accepted item waits in the input register; its result is then registered
// in the output register. Throughput: one item per cycle while the output is
// not stalled; the per-button update is one pass between the input register
// and the result register, so a sample of the same button may follow in the very next cycle.
// Reset (rst_n low, synchronous): both stages empty, all button state zero,
// configuration back to settle 10, window 300 ms, no buttons in use.
`timescale 1ns / 1ps
module button_debounce_click_detector_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] button_index, [3] pin_level, [35:4] now_ms, [39:36] zero
  input  logic [bdc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] button_id, [3] state_changed, [4] went_down, [5] went_up, [6] click,
  // [7] double_click, [8] debounced_level, [40:9] held_ms, [47:41] zero
  output logic [bdc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  bdc_pkg::cfg_t    cfg;
  bdc_pkg::item_t   s1_item_r;
  bdc_pkg::result_t res;
  bdc_pkg::result_t out_res_r;
  logic             s1_valid_r;
  logic             out_valid_r;
  logic             advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  bdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bdc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= in_tdata[35:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r};

  // A flip is always exactly one of press or release
  a_change_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.state_changed == (out_res_r.went_down ^ out_res_r.went_up)))
    else $error("state change not matched by one press or release");

  // Double clicks only come with a release
  a_dbl_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.double_click) |-> out_res_r.went_up)
    else $error("double click without release");

  // A press never carries a click
  a_no_click_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.went_down) |-> !out_res_r.click)
    else $error("click reported on press");

  // A held item in the input stage blocks new input
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |-> !in_tready)
    else $error("input accepted while stage is stalled");

  // A stalled result stays in the output register
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result lost or changed");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the button debounce and click detector unit.
`timescale 1ns / 1ps
module tb;

  typedef logic [bdc_pkg::IDX_W-1:0]      idx_t;
  typedef logic [bdc_pkg::TIME_W-1:0]     stamp_t;
  typedef logic [bdc_pkg::CFG_DATA_W-1:0] cfg_word_t;

  localparam logic [bdc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef struct {
    bdc_pkg::item_t sample;
    int unsigned    gap;
  } queued_sample_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [bdc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [bdc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_we = 1'b0;
  logic [bdc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bdc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the registers and of every button's state
  bdc_pkg::cfg_t       knobs;
  bdc_pkg::btn_state_t buttons [bdc_pkg::NUM_BUTTONS];

  queued_sample_t   pending_samples[$];
  queued_sample_t   next_up;
  bdc_pkg::result_t expected_events[$];
  bdc_pkg::item_t   on_bus;
  bdc_pkg::result_t want_r, got_r;
  logic [7:0]       pin_goal = '0;

  int unsigned idle_count = 0;
  int unsigned stall_left = 0;
  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;
  int unsigned samples_queued = 0;
  int unsigned samples_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned presses = 0, releases = 0, clicks = 0, doubles = 0, holds = 0;
  int unsigned fails = 0;

  button_debounce_click_detector_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Debounce one sample and work out the event flags it raises
  task automatic predict_sample(input bdc_pkg::item_t s);
    bdc_pkg::result_t r;
    int unsigned b;
    logic flipped;
    logic in_win;
    stamp_t since_click;
    r = '0;
    flipped = 1'b0;
    b = 32'(s.button_index);
    r.button_id = s.button_index;
    if (b < knobs.button_count) begin
      if (s.pin_level != buttons[b].stable_level) begin
        if (s.pin_level == buttons[b].previous_raw) begin
          buttons[b].agree_count = buttons[b].agree_count + 8'd1;
          if (buttons[b].agree_count == knobs.settle_count) begin
            buttons[b].stable_level = ~buttons[b].stable_level;
            buttons[b].agree_count = '0;
            flipped = 1'b1;
          end
        end else begin
          buttons[b].agree_count = '0;
        end
        buttons[b].previous_raw = s.pin_level;
      end
      since_click = s.now_ms - buttons[b].last_click_time;
      if (flipped) begin
        r.state_changed = 1'b1;
        buttons[b].hold_duration = '0;
        if (buttons[b].stable_level != knobs.pressed_level) begin
          in_win = buttons[b].click_valid && (since_click <= knobs.double_click_ms);
          r.went_up = 1'b1;
          r.double_click = in_win;
          r.click = ~knobs.exclusive_mode;
          // exclusive mode: a double click consumes the pending click
          if (knobs.exclusive_mode && in_win) begin
            buttons[b].click_valid = 1'b0;
          end else begin
            buttons[b].last_click_time = s.now_ms;
            buttons[b].click_valid = 1'b1;
          end
          buttons[b].press_time = '0;
        end else begin
          r.went_down = 1'b1;
          buttons[b].press_time = s.now_ms;
        end
      end else if (buttons[b].stable_level == knobs.pressed_level) begin
        buttons[b].hold_duration = s.now_ms - buttons[b].press_time;
        holds++;
      end else if (knobs.exclusive_mode && buttons[b].click_valid &&
                   since_click >= knobs.double_click_ms) begin
        r.click = 1'b1;
        buttons[b].click_valid = 1'b0;
      end
    end
    r.debounced_level = buttons[b].stable_level;
    r.held_ms = buttons[b].hold_duration;
    presses += r.went_down;
    releases += r.went_up;
    clicks += r.click;
    doubles += r.double_click;
    expected_events.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // Driver: present queued items after their drawn idle gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      idle_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_sample(on_bus);
        samples_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() != 0 && idle_count >= pending_samples[0].gap) begin
          next_up = pending_samples.pop_front();
          on_bus = next_up.sample;
          in_tdata <= {{(bdc_pkg::IN_DATA_W - $bits(bdc_pkg::item_t)){1'b0}},
                       next_up.sample};
          in_tvalid <= 1'b1;
          idle_count = 0;
        end else begin
          in_tvalid <= 1'b0;
          if (pending_samples.size() != 0) idle_count++;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          $error("result with nothing expected: %h", out_tdata);
          fails++;
        end else begin
          want_r = expected_events.pop_front();
          got_r = out_tdata[$bits(bdc_pkg::result_t)-1:0];
          check_field("button_id", 32'(want_r.button_id), 32'(got_r.button_id));
          check_field("state_changed", 32'(want_r.state_changed),
                      32'(got_r.state_changed));
          check_field("went_down", 32'(want_r.went_down), 32'(got_r.went_down));
          check_field("went_up", 32'(want_r.went_up), 32'(got_r.went_up));
          check_field("click", 32'(want_r.click), 32'(got_r.click));
          check_field("double_click", 32'(want_r.double_click),
                      32'(got_r.double_click));
          check_field("debounced_level", 32'(want_r.debounced_level),
                      32'(got_r.debounced_level));
          check_field("held_ms", want_r.held_ms, got_r.held_ms);
        end
        results_checked++;
        if (results_checked % 40 == 0) quiet_out = ($urandom_range(0, 3) == 0);
        stall_left = quiet_out ? 0 : $urandom_range(0, 17);
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic cfg_word_t with_junk(input int unsigned val, input int unsigned w);
    cfg_word_t junk;
    junk = ($urandom_range(0, 3) == 0) ? (cfg_word_t'($urandom) << w) : '0;
    return junk | cfg_word_t'(val);
  endfunction

  function automatic stamp_t next_stamp(input stamp_t t, input int unsigned step);
    return t + (($urandom_range(0, 49) == 0) ? stamp_t'($urandom)
                                              : stamp_t'($urandom_range(0, step)));
  endfunction

  task automatic write_reg(input logic [bdc_pkg::CFG_IDX_W-1:0] idx, input cfg_word_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bdc_pkg::CFG_SETTLE_COUNT:  knobs.settle_count = val[7:0];
      bdc_pkg::CFG_DOUBLE_CLICK:  knobs.double_click_ms = val[15:0];
      bdc_pkg::CFG_EXCLUSIVE:     knobs.exclusive_mode = val[0];
      bdc_pkg::CFG_PRESSED_LEVEL: knobs.pressed_level = val[0];
      bdc_pkg::CFG_BUTTON_COUNT:  knobs.button_count = val[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input int unsigned settle, input int unsigned window,
                             input int unsigned excl, input int unsigned pressed,
                             input int unsigned count);
    write_reg(bdc_pkg::CFG_SETTLE_COUNT, with_junk(settle, 8));
    write_reg(bdc_pkg::CFG_DOUBLE_CLICK, with_junk(window, 16));
    write_reg(bdc_pkg::CFG_EXCLUSIVE, with_junk(excl, 1));
    write_reg(bdc_pkg::CFG_PRESSED_LEVEL, with_junk(pressed, 1));
    write_reg(bdc_pkg::CFG_BUTTON_COUNT, with_junk(count, 4));
  endtask

  task automatic send(input idx_t b, input logic pin, input stamp_t t);
    queued_sample_t q;
    if (samples_queued % 40 == 0) quiet_in = ($urandom_range(0, 3) == 0);
    q.sample.button_index = b;
    q.sample.pin_level = pin;
    q.sample.now_ms = t;
    q.gap = quiet_in ? 0 : $urandom_range(0, 17);
    pending_samples.push_back(q);
    samples_queued++;
  endtask

  // Wait until every queued item is in and every result is out, with a limit
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while ((pending_samples.size() != 0 || in_tvalid || expected_events.size() != 0) &&
           waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_samples.size() != 0 || expected_events.size() != 0) begin
      $error("stuck: %0d items unsent, %0d results missing",
             pending_samples.size(), expected_events.size());
      fails++;
      expected_events.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // Mostly clean press and release runs with random timing, plus bounce and noise
  task automatic random_phase(input int unsigned target, input int unsigned step,
                              input bit one_button);
    int unsigned first, kind, run;
    idx_t b, pick;
    stamp_t t;
    first = samples_queued;
    t = $urandom;
    pick = idx_t'($urandom_range(0, bdc_pkg::NUM_BUTTONS - 1));
    while (samples_queued - first < target) begin
      b = one_button ? pick : idx_t'($urandom_range(0, bdc_pkg::NUM_BUTTONS - 1));
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        repeat ($urandom_range(1, 4)) begin
          t = next_stamp(t, step);
          send(idx_t'($urandom), 1'($urandom), t);
        end
      end else begin
        if (kind < 65) begin
          pin_goal[b] = ~pin_goal[b];
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              t = next_stamp(t, step);
              send(b, 1'($urandom), t);
            end
          end
          run = (knobs.settle_count == 0 ? 256 : knobs.settle_count) + $urandom_range(0, 2);
        end else begin
          run = $urandom_range(1, 6);
        end
        repeat (run) begin
          t = next_stamp(t, step);
          send(b, pin_goal[b], t);
        end
      end
    end
    drain();
  endtask

  initial begin
    knobs = '0;
    knobs.settle_count = bdc_pkg::SETTLE_RESET;
    knobs.double_click_ms = bdc_pkg::WINDOW_RESET;
    foreach (buttons[i]) buttons[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: press with time wrap, hold, click, double click, inactive button
    apply_setup(1, 300, 0, 1, 7);
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    send(3'd7, 1'b1, 32'h0000_0000);
    send(3'd0, 1'b1, 32'hFFFF_FF00);
    send(3'd0, 1'b1, 32'hFFFF_FF10);
    send(3'd0, 1'b1, 32'h0000_0010);
    send(3'd0, 1'b0, 32'h0000_0020);
    send(3'd0, 1'b0, 32'h0000_0030);
    send(3'd0, 1'b1, 32'h0000_0040);
    send(3'd0, 1'b1, 32'h0000_0050);
    send(3'd0, 1'b0, 32'h0000_0060);
    send(3'd0, 1'b0, 32'h0000_0070);
    send(3'd7, 1'b0, 32'hFFFF_FFFF);
    drain();

    // Directed, exclusive: leftover click after the switch, delayed click, double
    apply_setup(1, 300, 1, 1, 8);
    send(3'd0, 1'b0, 32'h0000_1000);
    send(3'd7, 1'b1, 32'd100);
    send(3'd7, 1'b1, 32'd101);
    send(3'd7, 1'b0, 32'd102);
    send(3'd7, 1'b0, 32'd103);
    send(3'd7, 1'b0, 32'd200);
    send(3'd7, 1'b0, 32'd403);
    send(3'd7, 1'b1, 32'd500);
    send(3'd7, 1'b1, 32'd501);
    send(3'd7, 1'b0, 32'd502);
    send(3'd7, 1'b0, 32'd503);
    send(3'd7, 1'b1, 32'd510);
    send(3'd7, 1'b1, 32'd511);
    send(3'd7, 1'b0, 32'd512);
    send(3'd7, 1'b0, 32'd513);
    drain();

    apply_setup(2, 300, 0, 1, 8);
    random_phase(250, 60, 1'b0);
    apply_setup(3, 0, 1, 0, 5);
    random_phase(200, 20, 1'b0);
    apply_setup(1, 65535, 0, 0, 8);
    random_phase(200, 3000, 1'b0);
    apply_setup(4, $urandom_range(1, 2000), 1, 1, 8);
    random_phase(250, knobs.double_click_ms / 4 + 1, 1'b0);
    apply_setup(255, 1000, 1, 0, 8);
    random_phase(300, 10, 1'b1);
    // a settle count of zero wraps, so a flip needs 256 agreeing samples
    apply_setup(0, 200, 0, 1, 8);
    random_phase(300, 10, 1'b1);
    apply_setup(10, 300, 0, 0, 0);
    random_phase(40, 100, 1'b0);

    $display("Checked %0d results for %0d samples: %0d presses, %0d releases, %0d clicks,",
             results_checked, samples_accepted, presses, releases, clicks);
    $display("%0d double clicks, %0d hold updates over both modes, polarities and 0..8 buttons",
             doubles, holds);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
